>>> design/rkpc_pkg.sv
// Shared types, constants and step functions for the four-key rotate cipher.
// No dependencies; every other design file imports this package.
package rkpc_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 65535;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_DATA  = 1'b1
  } req_t;

  typedef struct packed {
    logic        is_start;
    logic        decode;
    logic        word;
    logic        last;
    logic [15:0] pos;
    logic [63:0] data;
  } item_t;

  function automatic logic [63:0] fwd(input logic [63:0] x, input logic [63:0] m);
    logic [5:0]   q;
    logic [63:0]  s;
    logic [127:0] d;
    q = 6'($countones(m));
    s = x + m;
    d = {s, s} >> q;
    return d[63:0];
  endfunction

  function automatic logic [63:0] inv(input logic [63:0] x, input logic [63:0] m);
    logic [5:0]   q;
    logic [127:0] d;
    q = 6'($countones(m));
    d = {x, x} << q;
    return d[127:64] - m;
  endfunction

endpackage

>>> design/rkpc_front.sv
// Input side: accepts stream transactions, tracks packet bytes and tags each element.
// Depends on rkpc_pkg.
module rkpc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [87:0]     s_axis_tdata,
  input  logic            s_axis_tuser,
  input  logic            q_full,
  output logic            q_push,
  output rkpc_pkg::item_t q_item
);
  import rkpc_pkg::*;

  logic [15:0] left;
  logic [15:0] left_next;
  logic [15:0] len;
  logic        take;

  assign s_axis_tready = !q_full;
  assign take = s_axis_tvalid && s_axis_tready;

  always_comb begin
    len = s_axis_tdata[15:0];
    if (32'(len) > MAX_PACKET_BYTES) begin
      len = 16'(MAX_PACKET_BYTES);
    end
    q_item.decode = s_axis_tdata[16];
    q_item.data = s_axis_tdata[80:17];
    q_item.word = 1'b0;
    q_item.last = 1'b0;
    q_item.pos = len;
    q_item.is_start = 1'b0;
    left_next = left;
    q_push = 1'b0;
    if (req_t'(s_axis_tuser) == REQ_START) begin
      q_item.is_start = 1'b1;
      q_item.last = (len == 16'd0);
      left_next = len;
      q_push = take;
    end else if (left != 16'd0) begin
      q_item.word = (left >= 16'd8);
      left_next = q_item.word ? left - 16'd8 : left - 16'd1;
      q_item.pos = left_next;
      q_item.last = (left_next == 16'd0);
      q_push = take;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 16'd0;
    end else if (take) begin
      left <= left_next;
    end
  end

endmodule

>>> design/rkpc_queue.sv
// Short queue of tagged elements between the front and the back end.
// Depends on rkpc_pkg.
module rkpc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rkpc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output rkpc_pkg::item_t head
);
  import rkpc_pkg::*;

  item_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic                  do_push;
  logic                  do_pop;

  assign full = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end
  end

endmodule

>>> design/rkpc_back.sv
// Back end: key registers, working key state and the add-rotate step sequencer.
// Depends on rkpc_pkg.
module rkpc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [63:0]     cfg_data,
  input  logic            q_valid,
  input  rkpc_pkg::item_t q_head,
  output logic            q_pop,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [79:0]     m_axis_tdata,
  output logic            m_axis_tuser,
  output logic            m_axis_tlast
);
  import rkpc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_KEY  = 10'b0000000010,
    S_WORD = 10'b0000000100,
    S_WUPD = 10'b0000001000,
    S_BSUM = 10'b0000010000,
    S_BYTE = 10'b0000100000,
    S_BUPD = 10'b0001000000,
    S_SUM  = 10'b0010000000,
    S_FOLD = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  localparam logic [1:0] IDX_A = 2'd0;
  localparam logic [1:0] IDX_B = 2'd1;
  localparam logic [1:0] IDX_C = 2'd2;
  localparam logic [1:0] IDX_D = 2'd3;

  state_t      state;
  logic [2:0]  sub;
  item_t       cur;
  logic        dir;
  logic [63:0] key_a, key_b, key_c, key_d;
  logic [63:0] wa, wb, wc, wd;
  logic [63:0] acc, acc_next;
  logic [63:0] plain, res;
  logic [15:0] chk;
  logic [63:0] pos64;
  logic [63:0] mask;
  logic [63:0] s1, s2;
  logic [7:0]  bval;

  logic        out_valid;
  logic [63:0] out_data;
  logic [15:0] out_chk;
  logic        out_word;
  logic        out_last;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {out_chk, out_data};
  assign m_axis_tuser = out_word;
  assign m_axis_tlast = out_last;
  assign q_pop = (state == S_IDLE) && q_valid;
  assign pos64 = {48'd0, cur.pos};
  assign s1 = acc + (acc >> 32);
  assign s2 = s1 + (s1 >> 16);
  assign bval = dir ? cur.data[7:0] - acc[7:0] : cur.data[7:0];

  always_comb begin
    mask = pos64;
    unique case (sub)
      3'd0: mask = dir ? wd : pos64;
      3'd1: mask = dir ? wc : wa;
      3'd2: mask = wb;
      3'd3: mask = dir ? wa : wc;
      default: mask = dir ? pos64 : wd;
    endcase
    acc_next = dir ? inv(acc, mask) : fwd(acc, mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_a <= '0;
      key_b <= '0;
      key_c <= '0;
      key_d <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        IDX_A: key_a <= cfg_data;
        IDX_B: key_b <= cfg_data;
        IDX_C: key_c <= cfg_data;
        IDX_D: key_d <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sub <= '0;
      dir <= 1'b0;
      wa <= '0;
      wb <= '0;
      wc <= '0;
      wd <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          sub <= '0;
          if (q_valid) begin
            cur <= q_head;
            acc <= q_head.is_start ? 64'd0 : q_head.data;
            res <= '0;
            chk <= '0;
            if (q_head.is_start) begin
              dir <= q_head.decode;
              state <= S_KEY;
            end else if (q_head.word) begin
              state <= S_WORD;
            end else begin
              state <= S_BSUM;
            end
          end
        end
        S_KEY: begin
          sub <= sub + 3'd1;
          unique case (sub)
            3'd0: wa <= key_a + fwd(key_d, pos64);
            3'd1: wb <= key_b + fwd(key_c, pos64);
            3'd2: wc <= key_c + fwd(wb, pos64);
            default: begin
              wd <= key_d + fwd(wa, pos64);
              state <= cur.last ? S_SUM : S_IDLE;
            end
          endcase
        end
        S_WORD: begin
          acc <= acc_next;
          if (sub == 3'd4) begin
            res <= acc_next;
            plain <= dir ? acc_next : cur.data;
            sub <= '0;
            state <= S_WUPD;
          end else begin
            sub <= sub + 3'd1;
          end
        end
        S_WUPD: begin
          sub <= sub + 3'd1;
          unique case (sub)
            3'd0: wa <= wa + fwd(plain, pos64);
            3'd1: wb <= wb + fwd(wa, plain);
            3'd2: wc <= wc + fwd(wb, plain);
            default: begin
              wd <= wd + fwd(wc, plain);
              state <= cur.last ? S_SUM : S_OUT;
            end
          endcase
        end
        S_BSUM: begin
          sub <= sub + 3'd1;
          unique case (sub)
            3'd0: acc <= fwd(wa, pos64);
            3'd1: acc <= acc + fwd(wb, pos64);
            3'd2: acc <= acc + fwd(wc, pos64);
            default: begin
              acc <= acc + fwd(wd, pos64);
              state <= S_BYTE;
            end
          endcase
        end
        S_BYTE: begin
          plain <= {56'd0, bval};
          res <= {56'd0, dir ? bval : cur.data[7:0] + acc[7:0]};
          sub <= '0;
          state <= S_BUPD;
        end
        S_BUPD: begin
          sub <= sub + 3'd1;
          if (sub == 3'd0) begin
            wa <= wa + fwd(wb, plain);
          end else begin
            wb <= wb + fwd(plain, wa);
            state <= cur.last ? S_SUM : S_OUT;
          end
        end
        S_SUM: begin
          acc <= (wa + wb) + (wc + wd);
          state <= S_FOLD;
        end
        S_FOLD: begin
          chk <= s2[15:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_data <= res;
            out_chk <= chk;
            out_word <= cur.word;
            out_last <= cur.last;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fold_to_out: assert property (@(posedge clk) disable iff (rst)
    state == S_FOLD |=> state == S_OUT)
    else $error("fold not followed by output");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != S_IDLE && state != S_OUT)
    else $error("popped item not started");
  a_word_sub: assert property (@(posedge clk) disable iff (rst)
    state == S_WORD |-> sub <= 3'd4)
    else $error("word step count overrun");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && !out_valid |=> out_valid && state == S_IDLE)
    else $error("result not loaded");

endmodule

>>> design/rotate_key_packet_cipher_4key.sv
// Top level of the four-key rotate packet cipher: front, queue and back end.
// Depends on rkpc_pkg, rkpc_front, rkpc_queue and rkpc_back.
//
//   channel   dir  handshake                 payload
//   s_axis    in   tvalid/tready             tuser req_type, tdata fields
//   m_axis    out  tvalid/tready             tuser is_word, tlast last, tdata
//   cfg       in   cfg_we                    cfg_index, cfg_data
//
// In the back end a start item runs the key setup, a word element the add-rotate
// steps and the key update, a byte the weight sum, the byte step and the key update;
// the last element of a packet adds the key sum and fold, and an empty packet's start
// adds sum, fold and output. The back end does one add-rotate step per cycle.
// The four-entry queue keeps input accepted while the back end works, until it is full;
// a result held in the output register stalls the back end in its output step.
// Reset clears keys, working keys, queue pointers and the output valid flag at once.
module rotate_key_packet_cipher_4key (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // packet_length[15:0], decode_mode[16], data_in[80:17]
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // data_out[63:0], check_value[79:64]
  output logic        m_axis_tuser,   // is_word
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import rkpc_pkg::*;

  item_t push_item;
  item_t head;
  logic  push;
  logic  full;
  logic  pop;
  logic  valid;

  rkpc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (full),
    .q_push        (push),
    .q_item        (push_item)
  );

  rkpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .valid     (valid),
    .head      (head)
  );

  rkpc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_valid       (valid),
    .q_head        (head),
    .q_pop         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
